### src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle property, sampled on the rising clock edge, off during reset
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent now, consequent in the next cycle
`define CHK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/b64enc_pkg.sv
`default_nettype none
package b64enc_pkg;

    // configuration register indexes
    localparam logic CFG_PAD_ENABLE   = 1'b0;
    localparam logic CFG_URL_ALPHABET = 1'b1;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 1;

    // depth of the command queue between front and back
    localparam int CMD_DEPTH = 2;

    // up to four characters per input byte
    localparam int SLOT_COUNT = 4;
    localparam int SLOT_W     = 2;

    localparam logic [6:0] CHAR_UPPER_A = 7'h41;
    localparam logic [6:0] CHAR_UPPER_Z = 7'h5A;
    localparam logic [6:0] CHAR_LOWER_A = 7'h61;
    localparam logic [6:0] CHAR_LOWER_Z = 7'h7A;
    localparam logic [6:0] CHAR_ZERO    = 7'h30;
    localparam logic [6:0] CHAR_NINE    = 7'h39;
    localparam logic [6:0] CHAR_PLUS    = 7'h2B;
    localparam logic [6:0] CHAR_SLASH   = 7'h2F;
    localparam logic [6:0] CHAR_DASH    = 7'h2D;
    localparam logic [6:0] CHAR_UNDER   = 7'h5F;
    localparam logic [6:0] CHAR_PAD     = 7'h3D;

    typedef enum logic [1:0] {
        PHASE_0 = 2'd0,
        PHASE_1 = 2'd1,
        PHASE_2 = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } byte_item_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       out_last;
    } char_item_t;

    // one output character before alphabet mapping
    typedef struct packed {
        logic       is_pad;
        logic [5:0] sextet;
    } sym_t;

    // work for one input byte
    typedef struct packed {
        sym_t [SLOT_COUNT-1:0] syms;
        logic [SLOT_W-1:0]     last_idx;
        logic                  msg_end;
    } cmd_t;

    function automatic logic [6:0] sym_to_ascii(sym_t s, logic url);
        logic [6:0] v;
        logic [6:0] c;
        v = {1'b0, s.sextet};
        if (s.is_pad) begin
            c = CHAR_PAD;
        end else if (v < 7'd26) begin
            c = CHAR_UPPER_A + v;
        end else if (v < 7'd52) begin
            c = CHAR_LOWER_A + (v - 7'd26);
        end else if (v < 7'd62) begin
            c = CHAR_ZERO + (v - 7'd52);
        end else if (v == 7'd62) begin
            c = url ? CHAR_DASH : CHAR_PLUS;
        end else begin
            c = url ? CHAR_UNDER : CHAR_SLASH;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### src/b64enc_cmdq.sv
`default_nettype none
module b64enc_cmdq #(
    parameter int DEPTH = b64enc_pkg::CMD_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  b64enc_pkg::cmd_t      wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output b64enc_pkg::cmd_t      rd_data,
    output logic                  empty
);
    import b64enc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

### src/b64enc_front.sv
`default_nettype none
module b64enc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               take,
    input  b64enc_pkg::byte_item_t  item,
    input  wire logic               pad_enable,
    output b64enc_pkg::cmd_t        cmd
);
    import b64enc_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [3:0] lo_reg, lo_next;

    always_comb
    begin
        cmd        = '0;
        phase_next = phase_reg;
        lo_next    = lo_reg;
        case (phase_reg)
            PHASE_1:
            begin
                cmd.syms[0].sextet = {lo_reg[1:0], item.data_byte[7:4]};
                if (item.is_last)
                begin
                    cmd.syms[1].sextet = {item.data_byte[3:0], 2'b00};
                    cmd.syms[2].is_pad = 1'b1;
                    cmd.last_idx       = pad_enable ? 2'd2 : 2'd1;
                end
                phase_next = PHASE_2;
                lo_next    = item.data_byte[3:0];
            end
            PHASE_2:
            begin
                cmd.syms[0].sextet = {lo_reg, item.data_byte[7:6]};
                cmd.syms[1].sextet = item.data_byte[5:0];
                cmd.last_idx       = 2'd1;
                phase_next         = PHASE_0;
                lo_next            = '0;
            end
            default:
            begin
                // phase 0, and the unused code behaves the same
                cmd.syms[0].sextet = item.data_byte[7:2];
                if (item.is_last)
                begin
                    cmd.syms[1].sextet = {item.data_byte[1:0], 4'b0000};
                    cmd.syms[2].is_pad = 1'b1;
                    cmd.syms[3].is_pad = 1'b1;
                    cmd.last_idx       = pad_enable ? 2'd3 : 2'd1;
                end
                phase_next = PHASE_1;
                lo_next    = {2'b00, item.data_byte[1:0]};
            end
        endcase
        cmd.msg_end = item.is_last;
        if (item.is_last)
        begin
            phase_next = PHASE_0;
            lo_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_0;
            lo_reg    <= '0;
        end else if (take)
        begin
            phase_reg <= phase_next;
            lo_reg    <= lo_next;
        end
    end

endmodule
`default_nettype wire

### src/b64enc_back.sv
`default_nettype none
module b64enc_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_empty,
    input  b64enc_pkg::cmd_t        cmd,
    output logic                    cmd_pop,
    input  wire logic               url_alphabet,
    output b64enc_pkg::char_item_t  char_item,
    output logic                    empty,
    input  wire logic               pop
);
    import b64enc_pkg::*;

    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              valid_reg, valid_next;
    char_item_t        char_reg;
    logic              load;
    logic              at_end;

    assign empty     = !valid_reg;
    assign char_item = char_reg;
    assign at_end    = (idx_reg == cmd.last_idx);
    // output slot frees when empty or being taken this cycle
    assign load      = !cmd_empty && (!valid_reg || pop);
    assign cmd_pop   = load && at_end;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = at_end ? '0 : idx_reg + 1'b1;
        end else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg.out_char <= sym_to_ascii(cmd.syms[idx_reg], url_alphabet);
            char_reg.out_last <= cmd.msg_end && at_end;
        end
    end

endmodule
`default_nettype wire

### src/base64_stream_encoder_unit.sv
// channel   | handshake       | payload
// bytes     | push / full     | byte_item  (data_byte, is_last)
// chars     | pop / empty     | char_item  (out_char, out_last)
// config    | cfg_write       | cfg_index, cfg_data
//
// one byte accepted per cycle while the command queue has room
// back end: one char per cycle while popped; 1 or 2 per byte, up to 4 on a last byte
// sustained rate set by the character output
// a byte goes through the command queue, then its first character into the output register
// rst_n is asynchronous: empties the command queue and output register, restarts the group, loads register defaults
`default_nettype none
module base64_stream_encoder_unit #(
    parameter int CMD_QUEUE_DEPTH = b64enc_pkg::CMD_DEPTH
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  b64enc_pkg::byte_item_t                    byte_item,
    output logic                                      empty,
    input  wire logic                                 pop,
    output b64enc_pkg::char_item_t                    char_item,
    input  wire logic                                 cfg_write,
    input  wire logic [b64enc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [b64enc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import b64enc_pkg::*;

    // configuration registers
    logic pad_enable_reg;
    logic url_alphabet_reg;

    // front to queue
    cmd_t front_cmd;
    logic take;

    // queue to back
    cmd_t head_cmd;
    logic cmd_empty;
    logic cmd_pop;

    // a byte transfer needs a free queue entry
    assign take = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_enable_reg   <= 1'b1;
            url_alphabet_reg <= 1'b0;
        end else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PAD_ENABLE:   pad_enable_reg   <= cfg_data[0];
                CFG_URL_ALPHABET: url_alphabet_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // front: tracks group phase and leftover bits, splits each byte into symbols
    b64enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .item       (byte_item),
        .pad_enable (pad_enable_reg),
        .cmd        (front_cmd)
    );

    // short queue decouples byte intake from character output
    b64enc_cmdq #(
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take),
        .wr_data (front_cmd),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (head_cmd),
        .empty   (cmd_empty)
    );

    // back: walks the symbols of the head entry into the output register
    b64enc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_empty    (cmd_empty),
        .cmd          (head_cmd),
        .cmd_pop      (cmd_pop),
        .url_alphabet (url_alphabet_reg),
        .char_item    (char_item),
        .empty        (empty),
        .pop          (pop)
    );

endmodule
`default_nettype wire

### src/b64enc_checker.sv
`default_nettype none
`include "assert_macros.svh"
module b64enc_checker (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    empty,
    input wire logic                    pop,
    input b64enc_pkg::char_item_t       char_item
);
    import b64enc_pkg::*;

    logic [6:0] c;
    logic       legal;
    logic       is_pad;
    logic       stalled;
    logic       pad_open;
    logic       last_xfer;

    assign c      = char_item.out_char;
    assign is_pad = (c == CHAR_PAD);
    assign legal  = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
                    (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
                    (c >= CHAR_ZERO && c <= CHAR_NINE) ||
                    c == CHAR_PLUS || c == CHAR_SLASH ||
                    c == CHAR_DASH || c == CHAR_UNDER || is_pad;

    assign stalled   = !empty && !pop;
    assign pad_open  = !empty && pop && is_pad && !char_item.out_last;
    assign last_xfer = !empty && pop && char_item.out_last;

    // waiting character holds until taken
    `CHK_ASSERT_NEXT(a_hold, clk, rst_n, stalled, !empty && $stable(char_item), "char not held")

    // only alphabet or pad characters leave the block
    `CHK_ASSERT(a_legal, clk, rst_n, empty || legal, "illegal output character")

    // a pad that does not end the message is followed at once by a second pad
    `CHK_ASSERT_NEXT(a_pad_pair, clk, rst_n, pad_open, !empty && is_pad, "pad pair broken")

    // after the message end a pad never starts the next message
    `CHK_ASSERT_NEXT(a_no_lead_pad, clk, rst_n, last_xfer, empty || !is_pad, "pad opens message")

endmodule

bind base64_stream_encoder_unit b64enc_checker u_b64enc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .char_item (char_item)
);
`default_nettype wire
